FILE: hw/rtl/per_string_note_tracker_top_defines.svh
// Assertion macros shared by the note tracker RTL.
// Included by the modules that carry concurrent assertions.
`ifndef PER_STRING_NOTE_TRACKER_TOP_DEFINES_SVH
`define PER_STRING_NOTE_TRACKER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PNT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("note tracker assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PNT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("note tracker assertion failed");

`endif

FILE: hw/rtl/pnt_pkg.sv
// Package for the per-string note tracker: word types, command codes,
// control and status structs, and fixed arithmetic constants. No dependencies.
`timescale 1ns / 1ps

package pnt_pkg;

    localparam logic [1:0] CMD_ADD_TIME  = 2'd0;
    localparam logic [1:0] CMD_OPEN      = 2'd1;
    localparam logic [1:0] CMD_CLOSE     = 2'd2;
    localparam logic [1:0] CMD_CLOSE_ALL = 2'd3;

    localparam logic [6:0] OFF_VELOCITY = 7'd80;

    // Ticks added are floor(ratio * 480 / 1000) = floor(ratio * 12 / 25).
    // The division by 25 is a multiply by ceil(2^24 / 25) and a shift, exact
    // for every scaled value below 2^19.
    localparam int SCALED_W    = 19;
    localparam int QUOT_W      = 15;
    localparam int RECIP_W     = 20;
    localparam int RECIP_SHIFT = 24;
    localparam int PROD_W      = SCALED_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_M = 20'd671089;

    typedef struct packed {
        logic [1:0]  command;
        logic [3:0]  string_index;
        logic [6:0]  note;
        logic [6:0]  velocity;
        logic [3:0]  channel;
        logic [14:0] ratio;
    } t_in_word;

    typedef struct packed {
        logic        is_note_on;
        logic [3:0]  out_channel;
        logic [6:0]  out_note;
        logic [6:0]  out_velocity;
        logic [31:0] delta_time;
        logic        last;
    } t_out_word;

    typedef struct packed {
        logic load;
        logic idx_load;
        logic idx_clear;
        logic idx_inc;
        logic scale;
        logic accum;
        logic emit_off;
        logic emit_on;
        logic last;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] command;
        logic       in_range;
        logic       slot_valid;
        logic       idx_last;
        logic       above_empty;
        logic       out_free;
    } t_dp_sts;

endpackage

FILE: hw/rtl/pnt_datapath.sv
// Datapath of the note tracker: input register, string slots, tick
// accumulator with its scaler, and the output register. Uses pnt_pkg.
`timescale 1ns / 1ps
`include "per_string_note_tracker_top_defines.svh"

module pnt_datapath import pnt_pkg::*; #(
    parameter int NUM_STRINGS = 9
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_word  i_in_word,
    input  logic      i_out_stall,
    input  t_dp_cmd   i_cmd,
    output t_dp_sts   o_sts,
    output logic      o_out_valid,
    output t_out_word o_out_word
);

    localparam int IDX_W = (NUM_STRINGS > 1) ? $clog2(NUM_STRINGS) : 1;

    t_in_word                r_in;
    logic [SCALED_W-1:0]     r_scaled;
    logic [31:0]             r_pending;
    logic [IDX_W-1:0]        r_idx;
    logic [NUM_STRINGS-1:0]  r_valid;
    logic [6:0]              r_note [NUM_STRINGS];
    logic                    r_out_valid;
    t_out_word               r_out_word;

    logic [PROD_W-1:0]       w_prod;
    logic [QUOT_W-1:0]       w_quot;
    logic [NUM_STRINGS-1:0]  w_above;
    logic                    w_emit;

    assign w_prod  = PROD_W'(r_scaled) * PROD_W'(RECIP_M);
    assign w_quot  = w_prod[RECIP_SHIFT +: QUOT_W];
    assign w_above = r_valid >> r_idx;
    assign w_emit  = i_cmd.emit_off | i_cmd.emit_on;

    assign o_sts.command     = r_in.command;
    assign o_sts.in_range    = {1'b0, r_in.string_index} < 5'(NUM_STRINGS);
    assign o_sts.slot_valid  = r_valid[r_idx];
    assign o_sts.idx_last    = r_idx == IDX_W'(NUM_STRINGS - 1);
    assign o_sts.above_empty = (w_above >> 1) == '0;
    assign o_sts.out_free    = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in <= i_in_word;
        end
        if (i_cmd.scale) begin
            r_scaled <= {r_in.ratio, 4'b0} - {2'b0, r_in.ratio, 2'b0};
        end
        if (i_cmd.emit_on) begin
            r_note[r_idx] <= r_in.note;
        end
        if (i_cmd.emit_off) begin
            r_out_word.is_note_on   <= 1'b0;
            r_out_word.out_channel  <= r_in.channel;
            r_out_word.out_note     <= r_note[r_idx];
            r_out_word.out_velocity <= OFF_VELOCITY;
            r_out_word.delta_time   <= r_pending;
            r_out_word.last         <= i_cmd.last;
        end else if (i_cmd.emit_on) begin
            r_out_word.is_note_on   <= 1'b1;
            r_out_word.out_channel  <= r_in.channel;
            r_out_word.out_note     <= r_in.note;
            r_out_word.out_velocity <= r_in.velocity;
            r_out_word.delta_time   <= r_pending;
            r_out_word.last         <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending   <= '0;
            r_idx       <= '0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_emit) begin
                r_pending <= '0;
            end else if (i_cmd.accum) begin
                r_pending <= r_pending + 32'(w_quot);
            end
            if (i_cmd.idx_load) begin
                r_idx <= r_in.string_index[IDX_W-1:0];
            end else if (i_cmd.idx_clear) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + IDX_W'(1);
            end
            if (i_cmd.emit_off) begin
                r_valid[r_idx] <= 1'b0;
            end else if (i_cmd.emit_on) begin
                r_valid[r_idx] <= 1'b1;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    `PNT_ASSERT_IMPL(a_off_needs_note, i_clk, i_rst_n, i_cmd.emit_off, r_valid[r_idx])
    `PNT_ASSERT_IMPL(a_emit_needs_room, i_clk, i_rst_n, w_emit, o_sts.out_free)
    `PNT_ASSERT_NEXT(a_emit_clears_ticks, i_clk, i_rst_n, w_emit, r_pending == '0)
    `PNT_ASSERT_NEXT(a_on_marks_slot, i_clk, i_rst_n, i_cmd.emit_on, r_valid[$past(r_idx)])

endmodule

FILE: hw/rtl/pnt_ctrl.sv
// Controller of the note tracker: sequences command decode, tick scaling,
// slot scans and message emission. Uses pnt_pkg.
`timescale 1ns / 1ps

module pnt_ctrl import pnt_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_dp_sts i_sts,
    output logic    o_in_stall,
    output t_dp_cmd o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_SCALE  = 3'd2;
    localparam logic [2:0] S_ACCUM  = 3'd3;
    localparam logic [2:0] S_SCAN   = 3'd4;
    localparam logic [2:0] S_ON     = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       w_done;

    assign o_in_stall = (r_state != S_IDLE) || !i_rst_n;
    assign w_done     = (i_sts.command != CMD_CLOSE_ALL) || i_sts.idx_last;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_sts.command)
                    CMD_ADD_TIME: begin
                        n_state = S_SCALE;
                    end
                    CMD_CLOSE_ALL: begin
                        o_cmd.idx_clear = 1'b1;
                        n_state         = S_SCAN;
                    end
                    default: begin
                        if (i_sts.in_range) begin
                            o_cmd.idx_load = 1'b1;
                            n_state        = S_SCAN;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                endcase
            end
            S_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = S_ACCUM;
            end
            S_ACCUM: begin
                o_cmd.accum = 1'b1;
                n_state     = S_IDLE;
            end
            S_SCAN: begin
                if (!i_sts.slot_valid || i_sts.out_free) begin
                    o_cmd.emit_off = i_sts.slot_valid;
                    o_cmd.last     = (i_sts.command == CMD_CLOSE) ||
                                     ((i_sts.command == CMD_CLOSE_ALL) && i_sts.above_empty);
                    if (w_done) begin
                        n_state = (i_sts.command == CMD_OPEN) ? S_ON : S_IDLE;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                    end
                end
            end
            S_ON: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_on = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: hw/rtl/per_string_note_tracker_top.sv
// Top level of the per-string note tracker: joins controller and datapath.
// Depends on pnt_pkg, pnt_ctrl and pnt_datapath.
//
//   Channel   Direction  Word        Handshake
//   in        input      t_in_word   i_in_valid / o_in_stall
//   out       output     t_out_word  o_out_valid / i_out_stall
//
// One word is taken at a time. add_time is decoded, scaled and accumulated;
// open and close are decoded and scan their slot, then open emits its note-on.
// Out-of-range open or close ends at decode. close_all scans each slot in turn,
// one per cycle; a message waits while the output register is full and stalled.
// Reset empties every string slot and clears the tick accumulator at once.
`timescale 1ns / 1ps

module per_string_note_tracker_top import pnt_pkg::*; #(
    parameter int NUM_STRINGS = 9
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    pnt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (w_sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    pnt_datapath #(
        .NUM_STRINGS (NUM_STRINGS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (i_in_word),
        .i_out_stall (i_out_stall),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

endmodule
